/* sv/ctp_pkg.sv */
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants for the per-CPU tick percentage block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

  // configuration defaults
  localparam int NumCpusDefault = 8;

  // field widths
  localparam int CpuW     = 3;
  localparam int TicksW   = 64;
  localparam int PercentW = 7;

  // tick states per cpu and arithmetic constants
  localparam int TickStates = 5;
  localparam int DeltaW     = 31;
  localparam int TotalW     = 34;
  localparam int QuotW      = 10;
  localparam int DivW       = 44;
  localparam logic [DeltaW-1:0] DeltaClamp = {DeltaW{1'b1}};

  // input word
  typedef struct packed {
    logic [CpuW-1:0]   cpu_index;
    logic [TicksW-1:0] user_ticks;
    logic [TicksW-1:0] nice_ticks;
    logic [TicksW-1:0] system_ticks;
    logic [TicksW-1:0] interrupt_ticks;
    logic [TicksW-1:0] idle_ticks;
  } in_t;

  // output word
  typedef struct packed {
    logic [CpuW-1:0]     cpu_echo;
    logic [PercentW-1:0] user_percent;
    logic [PercentW-1:0] nice_percent;
    logic [PercentW-1:0] system_percent;
    logic [PercentW-1:0] interrupt_percent;
    logic [PercentW-1:0] idle_percent;
  } out_t;

endpackage

`default_nettype wire

/* sv/ctp_ram.sv */
// ----------------------------------------------------------------------------
// ctp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_ram #(
  parameter int Width = 64,
  parameter int Depth = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/cpu_tick_percentages.sv */
// A word for a cpu below NumCpus runs five counter reads, each with a delta
// step and write-back, then per share a numerator load, the 10-step divider
// and a percent step, then the result load; an out-of-range cpu goes straight
// to the result load. No word is taken before it. The shared restoring divider
// and the counter RAM set the rate. Reset clears per-cpu valid bits, so
// unwritten counters read as zero; the counter RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// cpu_tick_percentages
// Per-CPU tick state shares since the previous sample, computed by one
// shared divider under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_tick_percentages #(
  parameter int NumCpus = ctp_pkg::NumCpusDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ctp_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ctp_pkg::out_t      out_data_o
);

  import ctp_pkg::*;

  localparam int Depth = NumCpus * TickStates;
  localparam int AddrW = $clog2(Depth);
  localparam int CpuIdxW = (NumCpus > 1) ? $clog2(NumCpus) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DELTA,
    ST_NUMER,
    ST_DIV,
    ST_PCT,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [CpuW-1:0]     cpu_q;
  logic [TicksW-1:0]   cnt_q   [TickStates];
  logic [DeltaW-1:0]   delta_q [TickStates];
  logic [PercentW-1:0] pct_q   [TickStates];
  logic [2:0]          slot_q;
  logic [TotalW-1:0]   total_q;
  logic [DivW-1:0]     rem_q;
  logic [QuotW-1:0]    quot_q;
  logic [3:0]          bit_q;
  logic [NumCpus-1:0]  seen_q;
  logic                out_valid_q;
  out_t                out_q;

  logic                in_fire;
  logic                cpu_ok;
  logic [AddrW-1:0]    addr;
  logic [TicksW-1:0]   ram_rdata;
  logic [TicksW-1:0]   prev_cnt;
  logic [TicksW-1:0]   diff;
  logic [DeltaW-1:0]   delta_d;
  logic [TotalW-1:0]   total_d;
  logic [DivW-1:0]     numer_d;
  logic [DivW-1:0]     divisor_sh;
  logic                rem_ge;
  logic [20:0]         pct_prod;
  logic [PercentW-1:0] pct_d;
  logic                out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cpu_ok      = (32'(in_data_i.cpu_index) < NumCpus);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // ram address: cpu * 5 + slot
  assign addr = (AddrW'(cpu_q) << 2) + AddrW'(cpu_q) + AddrW'(slot_q);

  ctp_ram #(
    .Width (TicksW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_DELTA),
    .waddr_i (addr),
    .wdata_i (cnt_q[slot_q]),
    .re_i    (state_q == ST_READ),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  // clamped delta against the stored counter, zero if never written
  always_comb begin
    prev_cnt = seen_q[CpuIdxW'(cpu_q)] ? ram_rdata : '0;
    diff     = cnt_q[slot_q] - prev_cnt;
    delta_d  = (diff[TicksW-1:DeltaW] != '0) ? DeltaClamp : diff[DeltaW-1:0];
    total_d  = total_q + TotalW'(delta_d);
  end

  // numerator delta*1000 + total/2, the multiply as shifts
  always_comb begin
    numer_d = (DivW'(delta_q[slot_q]) << 10) - (DivW'(delta_q[slot_q]) << 4)
            - (DivW'(delta_q[slot_q]) << 3) + DivW'(total_q >> 1);
  end

  // shared divider step: one compare and subtract per cycle
  assign divisor_sh = DivW'(total_q) << bit_q;
  assign rem_ge     = (rem_q >= divisor_sh);

  // permille to percent, reciprocal of 10 exact below 1024
  assign pct_prod = 21'(quot_q) * 21'd205;
  assign pct_d    = pct_prod[17:11];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      bit_q       <= '0;
    end else begin
      // result handshake
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cpu_q    <= in_data_i.cpu_index;
            cnt_q[0] <= in_data_i.user_ticks;
            cnt_q[1] <= in_data_i.nice_ticks;
            cnt_q[2] <= in_data_i.system_ticks;
            cnt_q[3] <= in_data_i.interrupt_ticks;
            cnt_q[4] <= in_data_i.idle_ticks;
            for (int i = 0; i < TickStates; i++) begin
              pct_q[i] <= '0;
            end
            slot_q  <= '0;
            total_q <= '0;
            state_q <= cpu_ok ? ST_READ : ST_FINISH;
          end
        end
        ST_READ: begin
          state_q <= ST_DELTA;
        end
        ST_DELTA: begin
          delta_q[slot_q] <= delta_d;
          if (slot_q == 3'(TickStates - 1)) begin
            total_q                <= (total_d == '0) ? TotalW'(1) : total_d;
            seen_q[CpuIdxW'(cpu_q)] <= 1'b1;
            slot_q                 <= '0;
            state_q                <= ST_NUMER;
          end else begin
            total_q <= total_d;
            slot_q  <= slot_q + 3'd1;
            state_q <= ST_READ;
          end
        end
        ST_NUMER: begin
          rem_q   <= numer_d;
          quot_q  <= '0;
          bit_q   <= 4'(QuotW - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_q <= rem_q - divisor_sh;
          end
          quot_q <= {quot_q[QuotW-2:0], rem_ge};
          bit_q  <= bit_q - 4'd1;
          if (bit_q == '0) begin
            state_q <= ST_PCT;
          end
        end
        ST_PCT: begin
          pct_q[slot_q] <= pct_d;
          if (slot_q == 3'(TickStates - 1)) begin
            state_q <= ST_FINISH;
          end else begin
            slot_q  <= slot_q + 3'd1;
            state_q <= ST_NUMER;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_q.cpu_echo          <= cpu_q;
            out_q.user_percent      <= pct_q[0];
            out_q.nice_percent      <= pct_q[1];
            out_q.system_percent    <= pct_q[2];
            out_q.interrupt_percent <= pct_q[3];
            out_q.idle_percent      <= pct_q[4];
            state_q                 <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // permille quotient never exceeds 1000
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PCT) |-> (quot_q <= 10'd1000))
    else $error("permille quotient out of range");

  // divisor is never zero when a division starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NUMER) |-> (total_q != '0))
    else $error("zero divisor");

  // a new result only comes out of the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside finish");

  // an accepted word blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken while busy");
`endif

endmodule

`default_nettype wire
